>>> rtl/bqbc_pkg.sv
// ----------------------------------------------------------------------------
// bqbc_pkg
// Shared types and character constants for the bracket/quote balance checker.
// ----------------------------------------------------------------------------
package bqbc_pkg;

    // Codes held on the open stack
    typedef enum logic [1:0] {
        CODE_CURLY  = 2'd0,
        CODE_SQUARE = 2'd1,
        CODE_DQUOTE = 2'd2,
        CODE_SQUOTE = 2'd3
    } bqbc_code_t;

    // Verdict codes; also used for the latched error
    typedef enum logic [1:0] {
        VERDICT_VALID    = 2'd0,
        VERDICT_MISMATCH = 2'd1,
        VERDICT_UNCLOSED = 2'd2,
        VERDICT_OVERFLOW = 2'd3
    } bqbc_verdict_t;

    // Characters of interest
    localparam logic [7:0] CH_LCURLY  = 8'h7B;  // {
    localparam logic [7:0] CH_RCURLY  = 8'h7D;  // }
    localparam logic [7:0] CH_LSQUARE = 8'h5B;  // [
    localparam logic [7:0] CH_RSQUARE = 8'h5D;  // ]
    localparam logic [7:0] CH_DQUOTE  = 8'h22;  // "
    localparam logic [7:0] CH_SQUOTE  = 8'h27;  // '

    // Stack command, one per accepted item
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        bqbc_code_t code;
    } bqbc_stack_op_t;

endpackage

>>> rtl/bracket_quote_balance_checker.sv
// ----------------------------------------------------------------------------
// bracket_quote_balance_checker
// Checks nesting of {} [] "" '' across a byte stream, one verdict per message.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one text byte per item plus s_end_of_message on the last byte.
//   m_ channel: one 2-bit verdict per message (0 valid, 1 mismatched closer,
//   2 unclosed openings, 3 stack overflow), issued for the last byte only.
//   Throughput: one item per cycle, sustained while the skid register is empty. The stack top and the entry
//   under it sit in registers and the next entry down is prefetched from the
//   stack memory each cycle, so pops can follow each other back to back.
//   Output: the verdict is registered when the last byte is taken.
//   Stall: the result register plus a one-entry skid register absorb a stalled
//   m_ready; s_ready drops only while the skid register is full.
//   Reset (aresetn low, synchronous): stack empty, no error, no result
//   pending. The stack memory is not cleared; only written entries are used.
//   After each verdict the stack and error state clear for the next message.
// ----------------------------------------------------------------------------
module bracket_quote_balance_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_verdict
);

    localparam int LW = $clog2(STACK_DEPTH + 1);

    logic                      accept;
    logic [LW-1:0]             level;
    logic                      empty;
    logic                      full;
    bqbc_pkg::bqbc_code_t      top;
    bqbc_pkg::bqbc_stack_op_t  op;

    // Decoded request for this byte, before error and depth gating
    logic                      push_req;
    logic                      pop_req;
    logic                      mis_req;
    bqbc_pkg::bqbc_code_t      push_code;

    bqbc_pkg::bqbc_verdict_t   err_reg, err_next;
    bqbc_pkg::bqbc_verdict_t   err_after;
    logic                      busy;       // no error latched, byte counts
    logic                      do_push;
    logic                      do_pop;
    logic                      nonempty_after;
    bqbc_pkg::bqbc_verdict_t   res_verdict;
    logic                      res_valid;

    // Output register and skid register
    logic                      out_valid_reg, out_valid_next;
    bqbc_pkg::bqbc_verdict_t   out_verdict_reg, out_verdict_next;
    logic                      skid_valid_reg, skid_valid_next;
    bqbc_pkg::bqbc_verdict_t   skid_verdict_reg, skid_verdict_next;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign empty   = (level == '0);
    assign full    = (level == LW'(STACK_DEPTH));

    // Byte classification. Quotes toggle: close when the same quote is on
    // top, open otherwise. Closers need their partner on top.
    always_comb begin
        push_req  = 1'b0;
        pop_req   = 1'b0;
        mis_req   = 1'b0;
        push_code = bqbc_pkg::CODE_CURLY;
        unique case (s_text_byte)
            bqbc_pkg::CH_LCURLY: begin
                push_req  = 1'b1;
                push_code = bqbc_pkg::CODE_CURLY;
            end
            bqbc_pkg::CH_LSQUARE: begin
                push_req  = 1'b1;
                push_code = bqbc_pkg::CODE_SQUARE;
            end
            bqbc_pkg::CH_DQUOTE: begin
                push_code = bqbc_pkg::CODE_DQUOTE;
                if (!empty && top == bqbc_pkg::CODE_DQUOTE) begin
                    pop_req = 1'b1;
                end else begin
                    push_req = 1'b1;
                end
            end
            bqbc_pkg::CH_SQUOTE: begin
                push_code = bqbc_pkg::CODE_SQUOTE;
                if (!empty && top == bqbc_pkg::CODE_SQUOTE) begin
                    pop_req = 1'b1;
                end else begin
                    push_req = 1'b1;
                end
            end
            bqbc_pkg::CH_RCURLY: begin
                if (!empty && top == bqbc_pkg::CODE_CURLY) begin
                    pop_req = 1'b1;
                end else begin
                    mis_req = 1'b1;
                end
            end
            bqbc_pkg::CH_RSQUARE: begin
                if (!empty && top == bqbc_pkg::CODE_SQUARE) begin
                    pop_req = 1'b1;
                end else begin
                    mis_req = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Once an error is latched, the rest of the message is ignored
    assign busy    = (err_reg == bqbc_pkg::VERDICT_VALID);
    assign do_push = busy && push_req && !full;
    assign do_pop  = busy && pop_req;

    always_comb begin
        err_after = err_reg;
        if (busy && mis_req) begin
            err_after = bqbc_pkg::VERDICT_MISMATCH;
        end else if (busy && push_req && full) begin
            err_after = bqbc_pkg::VERDICT_OVERFLOW;
        end
    end

    // Stack occupancy after this byte
    always_comb begin
        priority if (do_push) begin
            nonempty_after = 1'b1;
        end else if (do_pop) begin
            nonempty_after = (level != LW'(1));
        end else begin
            nonempty_after = !empty;
        end
    end

    // Verdict: latched error first, then leftover openings
    always_comb begin
        priority if (err_after != bqbc_pkg::VERDICT_VALID) begin
            res_verdict = err_after;
        end else if (nonempty_after) begin
            res_verdict = bqbc_pkg::VERDICT_UNCLOSED;
        end else begin
            res_verdict = bqbc_pkg::VERDICT_VALID;
        end
    end

    assign res_valid = accept && s_end_of_message;

    // Stack command; the last byte of a message also empties the stack
    always_comb begin
        op.push  = accept && do_push;
        op.pop   = accept && do_pop;
        op.clear = accept && s_end_of_message;
        op.code  = push_code;
    end

    always_comb begin
        err_next = err_reg;
        if (accept) begin
            err_next = s_end_of_message ? bqbc_pkg::VERDICT_VALID : err_after;
        end
    end

    bqbc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .top     (top),
        .level   (level)
    );

    // Result path: output register, skid catches a result during a stall
    always_comb begin
        out_valid_next    = out_valid_reg;
        out_verdict_next  = out_verdict_reg;
        skid_valid_next   = skid_valid_reg;
        skid_verdict_next = skid_verdict_reg;
        if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next   = 1'b1;
                out_verdict_next = skid_verdict_reg;
                skid_valid_next  = 1'b0;
            end else begin
                out_valid_next   = res_valid;
                out_verdict_next = res_verdict;
            end
        end else if (res_valid) begin
            skid_valid_next   = 1'b1;
            skid_verdict_next = res_verdict;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg        <= bqbc_pkg::VERDICT_VALID;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_verdict_reg  <= out_verdict_next;
        skid_verdict_reg <= skid_verdict_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_verdict = out_verdict_reg;

    // A skid entry only exists behind a stalled output entry
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    // Stack never grows past its depth
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    // End of message leaves a clean stack and no error
    a_eom_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_end_of_message |=>
            level == '0 && err_reg == bqbc_pkg::VERDICT_VALID)
        else $error("state not cleared after end of message");

    // A latched error holds for the rest of the message
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_end_of_message && err_reg != bqbc_pkg::VERDICT_VALID |=>
            $stable(err_reg))
        else $error("latched error changed mid-message");

endmodule

>>> rtl/bqbc_stack.sv
// ----------------------------------------------------------------------------
// bqbc_stack
// Open stack: top and second entry in registers, the rest in a memory.
// ----------------------------------------------------------------------------
module bqbc_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bqbc_pkg::bqbc_stack_op_t         op,
    output bqbc_pkg::bqbc_code_t             top,
    output logic [$clog2(STACK_DEPTH+1)-1:0] level
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Entries 0 .. level-2 live in memory; entry level-1 lives in top_reg.
    bqbc_pkg::bqbc_code_t mem [STACK_DEPTH];

    logic [LW-1:0]        level_reg, level_next;
    bqbc_pkg::bqbc_code_t top_reg, top_next;
    bqbc_pkg::bqbc_code_t fwd_reg, fwd_next;
    logic                 fwd_valid_reg, fwd_valid_next;
    bqbc_pkg::bqbc_code_t rd_data_reg;
    bqbc_pkg::bqbc_code_t second;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [LW-1:0]        rd_level;
    logic                 wr_en;

    // Entry below the top: just-pushed old top, else the prefetched word
    assign second = fwd_valid_reg ? fwd_reg : rd_data_reg;

    always_comb begin
        level_next     = level_reg;
        top_next       = top_reg;
        fwd_next       = fwd_reg;
        fwd_valid_next = fwd_valid_reg;
        if (op.push) begin
            level_next     = level_reg + LW'(1);
            top_next       = op.code;
            fwd_next       = top_reg;
            fwd_valid_next = 1'b1;
        end else if (op.pop) begin
            level_next     = level_reg - LW'(1);
            top_next       = second;
            fwd_valid_next = 1'b0;
        end
        if (op.clear) begin
            level_next = '0;
        end
    end

    // Old top spills to memory on a push onto a nonempty stack
    assign wr_en    = op.push && (level_reg != '0);
    assign wr_addr  = AW'(level_reg - LW'(1));
    // Prefetch the entry that will sit under the new top (wraps when unused)
    assign rd_level = level_next - LW'(2);
    assign rd_addr  = AW'(rd_level);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= top_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            level_reg     <= level_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        fwd_reg <= fwd_next;
    end

    assign top   = top_reg;
    assign level = level_reg;

endmodule

>>> test/bqbc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bqbc_checker
// Watches both channels of the balance checker, tracks the bracket and quote
// stack itself and compares every verdict with the one it predicted.
// ----------------------------------------------------------------------------
module bqbc_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_end_of_message,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_verdict,
    output int         fail_count,
    output int         verdicts_waiting,
    output int         verdicts_checked,
    output int         seen_valid,
    output int         seen_mismatch,
    output int         seen_unclosed,
    output int         seen_overflow
);

    bqbc_pkg::bqbc_code_t    nest_stack [STACK_DEPTH];
    int                      nest_level;
    bqbc_pkg::bqbc_verdict_t latched_err;
    bqbc_pkg::bqbc_verdict_t verdict_q [$];
    bqbc_pkg::bqbc_verdict_t want;
    int                      n_fail;
    int                      n_checked;
    int                      n_kind [4];

    function automatic bit top_is(bqbc_pkg::bqbc_code_t c);
        return nest_level != 0 && nest_stack[nest_level - 1] == c;
    endfunction

    function automatic void push_code(bqbc_pkg::bqbc_code_t c);
        if (nest_level >= STACK_DEPTH) begin
            latched_err = bqbc_pkg::VERDICT_OVERFLOW;
        end else begin
            nest_stack[nest_level] = c;
            nest_level++;
        end
    endfunction

    // one byte through the stack; bytes after an error are dropped
    function automatic void track_char(logic [7:0] b);
        if (latched_err != bqbc_pkg::VERDICT_VALID) return;
        case (b)
            bqbc_pkg::CH_LCURLY:  push_code(bqbc_pkg::CODE_CURLY);
            bqbc_pkg::CH_LSQUARE: push_code(bqbc_pkg::CODE_SQUARE);
            bqbc_pkg::CH_DQUOTE: begin
                if (top_is(bqbc_pkg::CODE_DQUOTE)) nest_level--;
                else push_code(bqbc_pkg::CODE_DQUOTE);
            end
            bqbc_pkg::CH_SQUOTE: begin
                if (top_is(bqbc_pkg::CODE_SQUOTE)) nest_level--;
                else push_code(bqbc_pkg::CODE_SQUOTE);
            end
            bqbc_pkg::CH_RCURLY: begin
                if (top_is(bqbc_pkg::CODE_CURLY)) nest_level--;
                else latched_err = bqbc_pkg::VERDICT_MISMATCH;
            end
            bqbc_pkg::CH_RSQUARE: begin
                if (top_is(bqbc_pkg::CODE_SQUARE)) nest_level--;
                else latched_err = bqbc_pkg::VERDICT_MISMATCH;
            end
            default: ;
        endcase
    endfunction

    function automatic void note_fail(bqbc_pkg::bqbc_verdict_t e, logic [1:0] got,
                                      bit orphan);
        if (n_fail < 10) begin
            if (orphan)
                $display("[%0t] verdict %0d with no message pending", $realtime, got);
            else
                $display("[%0t] verdict mismatch: expected %0d got %0d", $realtime, e, got);
        end
        n_fail++;
    endfunction

    initial begin
        n_fail     = 0;
        n_checked  = 0;
        n_kind     = '{0, 0, 0, 0};
        nest_level = 0;
        latched_err = bqbc_pkg::VERDICT_VALID;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            nest_level  = 0;
            latched_err = bqbc_pkg::VERDICT_VALID;
            verdict_q.delete();
        end else begin
            // output side first, so a result never matches a verdict formed this edge
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    note_fail(bqbc_pkg::VERDICT_VALID, m_verdict, 1'b1);
                end else begin
                    want = verdict_q.pop_front();
                    n_checked++;
                    if (m_verdict !== want) note_fail(want, m_verdict, 1'b0);
                    else n_kind[want]++;
                end
            end
            if (s_valid && s_ready) begin
                track_char(s_text_byte);
                if (s_end_of_message) begin
                    if (latched_err != bqbc_pkg::VERDICT_VALID)
                        verdict_q.insert(verdict_q.size(), latched_err);
                    else if (nest_level != 0)
                        verdict_q.insert(verdict_q.size(), bqbc_pkg::VERDICT_UNCLOSED);
                    else
                        verdict_q.insert(verdict_q.size(), bqbc_pkg::VERDICT_VALID);
                    nest_level  = 0;
                    latched_err = bqbc_pkg::VERDICT_VALID;
                end
            end
        end
        fail_count       <= n_fail;
        verdicts_waiting <= verdict_q.size();
        verdicts_checked <= n_checked;
        seen_valid       <= n_kind[bqbc_pkg::VERDICT_VALID];
        seen_mismatch    <= n_kind[bqbc_pkg::VERDICT_MISMATCH];
        seen_unclosed    <= n_kind[bqbc_pkg::VERDICT_UNCLOSED];
        seen_overflow    <= n_kind[bqbc_pkg::VERDICT_OVERFLOW];
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives text messages into the bracket/quote balance checker: a handful of
// hand-picked corner cases, then random nested, broken, noisy and very deep
// messages, with random gaps on the input and random back-pressure on the
// verdict channel. The checker module beside the block does the prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH       = 64;
    localparam int ITEM_TARGET = 900;     // input items to send
    localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
    localparam int DRAIN       = 20;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_text_byte;
    logic       s_end_of_message;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_verdict;

    int fail_count, verdicts_waiting, verdicts_checked;
    int seen_valid, seen_mismatch, seen_unclosed, seen_overflow;

    int         cycle_count;
    int         items_sent;      // every accepted item
    int         msg_count;
    bit         calm;            // no input gaps for the current message
    logic [7:0] msg_buf [$];     // message under construction
    int         ready_hold;      // cycles left in current m_ready state

    bracket_quote_balance_checker #(
        .STACK_DEPTH(DEPTH)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_byte      (s_text_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict        (m_verdict)
    );

    bqbc_checker #(
        .STACK_DEPTH(DEPTH)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_byte      (s_text_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict        (m_verdict),
        .fail_count       (fail_count),
        .verdicts_waiting (verdicts_waiting),
        .verdicts_checked (verdicts_checked),
        .seen_valid       (seen_valid),
        .seen_mismatch    (seen_mismatch),
        .seen_unclosed    (seen_unclosed),
        .seen_overflow    (seen_overflow)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // all inputs known from time zero
    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_text_byte      = 8'h00;
        s_end_of_message = 1'b0;
        m_ready          = 1'b0;
        ready_hold       = 0;
        cycle_count      = 0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, verdicts_waiting);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Back-pressure on the verdict channel: ready stretches mixed with
    // stalls, both mostly short ones and now and then a long one.
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                m_ready    <= 1'b1;
                ready_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                          : $urandom_range(1, 6);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    function automatic bit is_special(logic [7:0] b);
        return b == bqbc_pkg::CH_LCURLY  || b == bqbc_pkg::CH_RCURLY  ||
               b == bqbc_pkg::CH_LSQUARE || b == bqbc_pkg::CH_RSQUARE ||
               b == bqbc_pkg::CH_DQUOTE  || b == bqbc_pkg::CH_SQUOTE;
    endfunction

    function automatic logic [7:0] any_special();
        case ($urandom_range(0, 5))
            0: return bqbc_pkg::CH_LCURLY;
            1: return bqbc_pkg::CH_RCURLY;
            2: return bqbc_pkg::CH_LSQUARE;
            3: return bqbc_pkg::CH_RSQUARE;
            4: return bqbc_pkg::CH_DQUOTE;
            default: return bqbc_pkg::CH_SQUOTE;
        endcase
    endfunction

    // a byte the stack ignores; all specials sit below 0x80, so flipping
    // bit 7 moves one out of the way and keeps every other bit pattern reachable
    function automatic logic [7:0] filler();
        logic [7:0] b;
        b = $urandom_range(0, 255);
        if (is_special(b)) b = b ^ 8'h80;
        return b;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One item: hold valid and payload until the handshake completes.
    // A gap lowers valid first, in an earlier step than the raise.
    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_text_byte      <= b;
        s_end_of_message <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // ships msg_buf as one message, last byte flagged
    task automatic send_message();
        if (msg_buf.size() == 0) msg_buf.insert(msg_buf.size(), filler());
        for (int i = 0; i < msg_buf.size(); i++)
            send_item(msg_buf[i], i == msg_buf.size() - 1);
        msg_buf.delete();
        msg_count++;
    endtask

    task automatic directed_message(input string txt);
        for (int i = 0; i < txt.len(); i++) msg_buf.insert(msg_buf.size(), txt[i]);
        send_message();
    endtask

    function automatic logic [7:0] closer_of(logic [7:0] op);
        if (op == bqbc_pkg::CH_LCURLY)  return bqbc_pkg::CH_RCURLY;
        if (op == bqbc_pkg::CH_LSQUARE) return bqbc_pkg::CH_RSQUARE;
        return op;  // quotes close themselves
    endfunction

    // Opening character that really pushes: a quote equal to the open
    // quote on top would close it, so use a curly instead.
    function automatic logic [7:0] pick_opener(logic [7:0] top_closer, bit has_top);
        logic [7:0] op;
        case ($urandom_range(0, 3))
            0: op = bqbc_pkg::CH_LCURLY;
            1: op = bqbc_pkg::CH_LSQUARE;
            2: op = bqbc_pkg::CH_DQUOTE;
            default: op = bqbc_pkg::CH_SQUOTE;
        endcase
        if (has_top && (op == bqbc_pkg::CH_DQUOTE || op == bqbc_pkg::CH_SQUOTE) &&
            top_closer == op)
            op = bqbc_pkg::CH_LCURLY;
        return op;
    endfunction

    // balanced nesting with random filler; sometimes broken afterwards
    function automatic void build_nested(int max_depth, int len);
        logic [7:0] closers [$];
        logic [7:0] op;
        int         r;
        int         pos;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            if (r < 3 && closers.size() < max_depth) begin
                op = pick_opener(closers.size() ? closers[$] : 8'h00, closers.size() != 0);
                msg_buf.insert(msg_buf.size(), op);
                closers.insert(closers.size(), closer_of(op));
            end else if (r < 6 && closers.size() > 0) begin
                msg_buf.insert(msg_buf.size(), closers.pop_back());
            end else begin
                msg_buf.insert(msg_buf.size(), filler());
            end
        end
        while (closers.size() > 0) msg_buf.insert(msg_buf.size(), closers.pop_back());

        if (msg_buf.size() > 0 && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: if (msg_buf.size() > 1) void'(msg_buf.pop_back());
                1: begin
                    pos = $urandom_range(0, msg_buf.size() - 1);
                    msg_buf[pos] = any_special();
                end
                default: msg_buf.push_front(($urandom_range(0, 1)) ? bqbc_pkg::CH_RCURLY
                                                                   : bqbc_pkg::CH_RSQUARE);
            endcase
        end
    endfunction

    // Nests depth openers, then closes them all; depth > DEPTH overflows
    function automatic void build_deep(int depth);
        logic [7:0] closers [$];
        logic [7:0] op;
        for (int i = 0; i < depth; i++) begin
            op = pick_opener(closers.size() ? closers[$] : 8'h00, closers.size() != 0);
            msg_buf.insert(msg_buf.size(), op);
            closers.insert(closers.size(), closer_of(op));
        end
        while (closers.size() > 0) msg_buf.insert(msg_buf.size(), closers.pop_back());
    endfunction

    // random bytes heavy in specials
    function automatic void build_noise();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) msg_buf.insert(msg_buf.size(),
                                  $urandom_range(0, 1) ? any_special() : filler());
    endfunction

    initial begin
        int deep_done;
        int pick;

        items_sent = 0;
        msg_count  = 0;
        deep_done  = 0;
        calm       = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed corners ----
        directed_message("{}");           // plain pair
        directed_message("[\"'']\"");     // square closer with a quote still open
        directed_message("}");            // closer on an empty stack
        directed_message("'");            // quote on an empty stack is pushed
        msg_buf.insert(msg_buf.size(), bqbc_pkg::CH_LCURLY);  // mismatch, then ignored bytes
        msg_buf.insert(msg_buf.size(), bqbc_pkg::CH_RSQUARE);
        msg_buf.insert(msg_buf.size(), bqbc_pkg::CH_LCURLY);
        msg_buf.insert(msg_buf.size(), 8'hFF);
        send_message();
        directed_message("\"}");          // curly closer against a quote on top
        msg_buf.insert(msg_buf.size(), 8'h00);  // byte extremes, each a message of its own
        send_message();
        msg_buf.insert(msg_buf.size(), 8'hFF);
        send_message();
        directed_message("[[{");          // leftover openers
        directed_message("\"\"");         // quote pops itself
        directed_message("]");            // square closer on an empty stack

        // ---- random part ----
        while (items_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (msg_count % 12 == 5 && deep_done < 5) begin
                case (deep_done)
                    0: build_deep(DEPTH);           // exactly full
                    1: build_deep(DEPTH + 1);       // first overflow
                    2: build_deep(DEPTH - 1);
                    default: build_deep($urandom_range(DEPTH - 4, DEPTH + 4));
                endcase
                deep_done++;
            end else if (pick < 75) begin
                build_nested($urandom_range(1, 8), $urandom_range(1, 20));
            end else begin
                build_noise();
            end
            send_message();
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // the last verdict is queued at the edge that took the last byte
        @(posedge aclk);
        while (verdicts_waiting != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("covered %0d items in %0d messages, %0d verdicts compared",
                 items_sent, msg_count, verdicts_checked);
        $display("verdicts: valid %0d, mismatch %0d, unclosed %0d, overflow %0d",
                 seen_valid, seen_mismatch, seen_unclosed, seen_overflow);
        if (fail_count == 0 && verdicts_waiting == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
